>>> sv/epm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epm_pkg
// Types and constants shared by the exact pattern matcher files.
// ----------------------------------------------------------------------------
package epm_pkg;

   // Field widths of the request and the length register.
   localparam int unsigned ModeWidth   = 1;
   localparam int unsigned IndexWidth  = 6;
   localparam int unsigned SymbolWidth = 8;
   localparam int unsigned LengthWidth = 7;

   // Request mode codes.
   localparam logic [ModeWidth-1:0] MODE_PATTERN = 1'b0;
   localparam logic [ModeWidth-1:0] MODE_TEXT    = 1'b1;

   // Per-cell control, decoded from the pattern length.
   typedef struct packed {
      logic enable; // cell position is inside the active pattern
      logic top;    // cell holds the last active pattern position
   } epm_cell_ctrl_type;

endpackage

>>> sv/epm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epm_req_if / epm_rsp_if
// Valid/ready channels for requests (pattern writes, text bytes) and for
// match responses.
// ----------------------------------------------------------------------------
interface epm_req_if
   import epm_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [ModeWidth-1:0]   mode;
   logic [IndexWidth-1:0]  index;
   logic [SymbolWidth-1:0] symbol;
   logic                   text_last;

   modport source (output valid, output mode, output index, output symbol,
                   output text_last, input ready);
   modport sink   (input valid, input mode, input index, input symbol,
                   input text_last, output ready);
endinterface

interface epm_rsp_if;
   logic valid;
   logic ready;
   logic found;

   modport source (output valid, output found, input ready);
   modport sink   (input valid, input found, output ready);
endinterface

>>> sv/exact_pattern_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exact_pattern_matcher
// Streams text bytes through a row of pattern cells and reports, at the end
// of each text, whether the pattern occurred anywhere in it.
//
//   Channel  Direction  Transaction
//   req_if   in         pattern byte write (mode 0) or one text byte (mode 1)
//   rsp_if   out        found flag, one per text byte marked last
//   csr_*    in         pattern_length write, no handshake
//
// One request is accepted every cycle unless stalled; the cell row updates in
// the cycle of acceptance. After the last text byte is accepted, its response
// passes the stage-one register, then the output register. Reset clears the
// match bits, the sticky found flag and the pipeline valid bits; pattern bytes
// are undefined until written. Requests stall only while a response waits in
// the output register and a second one is ready behind it.
// ----------------------------------------------------------------------------
module exact_pattern_matcher
   import epm_pkg::*;
#(
   parameter int unsigned PATTERN_MAX = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   epm_req_if.sink                req_if,
   epm_rsp_if.source              rsp_if,
   input  logic                   csr_write_en,
   input  logic [LengthWidth-1:0] csr_write_data
);

   logic [LengthWidth-1:0] length_ff;
   logic                   accept;
   logic                   text_step;
   logic                   text_clear;
   logic                   stall;
   logic                   s1_valid_ff;
   logic                   s1_last_ff;
   logic                   seen_ff;
   logic                   seen_in;
   logic                   hit;
   logic                   found_now;
   logic                   out_valid_ff;
   logic                   out_found_ff;
   logic [PATTERN_MAX:0]   match_chain;
   logic [PATTERN_MAX-1:0] hit_leaf;

   // Pattern length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LengthWidth'(1);
      end else if (csr_write_en) begin
         length_ff <= csr_write_data;
      end
   end

   // Request handshake.
   assign stall      = s1_valid_ff & s1_last_ff & out_valid_ff & ~rsp_if.ready;
   assign req_if.ready = ~stall;
   assign accept     = req_if.valid & ~stall;
   assign text_step  = accept & (req_if.mode == MODE_TEXT);
   assign text_clear = req_if.text_last;

   // Row of pattern cells.
   assign match_chain[0] = 1'b1;

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      epm_cell_ctrl_type ctrl;
      logic              char_write;

      assign ctrl.enable = (32'(length_ff) > j);
      assign ctrl.top    = (32'(length_ff) == j + 1) ||
                           ((j == PATTERN_MAX - 1) && (32'(length_ff) > PATTERN_MAX));
      assign char_write  = accept & (req_if.mode == MODE_PATTERN) &
                           (32'(req_if.index) == j);

      epm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .char_write (char_write),
         .text_step  (text_step),
         .text_clear (text_clear),
         .symbol     (req_if.symbol),
         .ctrl       (ctrl),
         .match_left (match_chain[j]),
         .match_out  (match_chain[j+1]),
         .hit_out    (hit_leaf[j])
      );
   end

   // Stage one: which text byte the registered hit leaves belong to.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= text_step;
         s1_last_ff  <= req_if.text_last;
      end
   end

   // Full match on this byte; an empty pattern matches everywhere.
   assign hit       = (|hit_leaf) | (length_ff == '0);
   assign found_now = seen_ff | hit;

   // Sticky found flag, cleared at the end of each text.
   always_comb begin
      seen_in = seen_ff;
      if (s1_valid_ff && !stall) begin
         seen_in = s1_last_ff ? 1'b0 : found_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_valid_ff && s1_last_ff && !stall) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_last_ff && !stall) begin
         out_found_ff <= found_now;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.found = out_found_ff;

endmodule

>>> sv/epm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epm_cell
// One pattern position: holds the pattern byte and the partial-match bit,
// updates that bit from its left neighbor's on every text byte, and clears it on the last byte of a text.
// ----------------------------------------------------------------------------
module epm_cell
   import epm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   char_write,
   input  logic                   text_step,
   input  logic                   text_clear,
   input  logic [SymbolWidth-1:0] symbol,
   input  epm_cell_ctrl_type      ctrl,
   input  logic                   match_left,
   output logic                   match_out,
   output logic                   hit_out
);

   logic [SymbolWidth-1:0] char_ff;
   logic                   match_ff;
   logic                   hit_ff;
   logic                   match_new;
   logic                   match_in;

   // Pattern byte store, written by index.
   always_ff @(posedge clock) begin
      if (char_write) begin
         char_ff <= symbol;
      end
   end

   // The prefix ending here matches if the left prefix matched and this byte agrees.
   assign match_new = match_left & ctrl.enable & (char_ff == symbol);
   assign match_in  = text_clear ? 1'b0 : match_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (text_step) begin
         match_ff <= match_in;
      end
   end

   // Full-match leaf: only the last active position reports.
   always_ff @(posedge clock) begin
      if (text_step) begin
         hit_ff <= match_new & ctrl.top;
      end
   end

   assign match_out = match_ff;
   assign hit_out   = hit_ff;

endmodule

>>> sv/epm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epm_checker
// Port-level checks of the exact pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
module epm_checker
   import epm_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [ModeWidth-1:0] req_mode,
   input logic                 req_text_last,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_found
);

   logic last_accept;

   assign last_accept = req_valid & req_ready & (req_mode == MODE_TEXT) & req_text_last;

   // A waiting response stays valid.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A waiting response keeps its value.
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found))
      else $error("response changed while stalled");

   // A fresh response follows an accepted end of a text.
   a_rsp_origin : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(last_accept, 2))
      else $error("response without a text end");

   // Requests stall only behind a blocked response.
   a_req_stall : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled with a free output");

endmodule

bind exact_pattern_matcher epm_checker u_epm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_mode      (req_if.mode),
   .req_text_last (req_if.text_last),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_found     (rsp_if.found)
);
